FILE: rtl/core/gam_pkg.sv
// ----------------------------------------------------------------------------
// gam_pkg
// Shared constants, types and tables of the gradient angle map.
// ----------------------------------------------------------------------------
`default_nettype none
package gam_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 10;
  localparam int DIM_W        = ((COL_W > 11) ? COL_W : 11) + 2;
  localparam int PIX_W        = 8;

  localparam int ANGLE_BITS   = 16;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SHIFT    = ANG_FRAC + 1 - ANGLE_BITS;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam int XY_W         = 29;
  localparam int Z_W          = 27;
  localparam int SQ_W         = 25;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  typedef struct packed {
    logic [12:0] norm;
    logic [15:0] angle;
  } gam_result_t;

  // Arctangent of 2^-i, with 2^24 standing for pi.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:    v = 27'sd4194304;
      5'd1:    v = 27'sd2476042;
      5'd2:    v = 27'sd1308273;
      5'd3:    v = 27'sd664100;
      5'd4:    v = 27'sd333339;
      5'd5:    v = 27'sd166832;
      5'd6:    v = 27'sd83436;
      5'd7:    v = 27'sd41721;
      5'd8:    v = 27'sd20861;
      5'd9:    v = 27'sd10430;
      5'd10:   v = 27'sd5215;
      5'd11:   v = 27'sd2608;
      5'd12:   v = 27'sd1304;
      5'd13:   v = 27'sd652;
      5'd14:   v = 27'sd326;
      5'd15:   v = 27'sd163;
      5'd16:   v = 27'sd81;
      5'd17:   v = 27'sd41;
      5'd18:   v = 27'sd20;
      5'd19:   v = 27'sd10;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gam_ram.sv
// ----------------------------------------------------------------------------
// gam_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module gam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/core/gam_math.sv
// ----------------------------------------------------------------------------
// gam_math
// Iterative gradient norm (bit-serial square root) and vectoring CORDIC angle.
// ----------------------------------------------------------------------------
`default_nettype none
module gam_math (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire signed [8:0]        ad_i,
  input  wire signed [8:0]        bc_i,
  output logic                    done_o,
  output gam_pkg::gam_result_t    res_o
);

  logic                                  busy_q, done_q, zero_q;
  logic [gam_pkg::STEP_W-1:0]            step_q;
  logic signed [gam_pkg::XY_W-1:0]       x_q, y_q;
  logic signed [gam_pkg::Z_W-1:0]        z_q;
  logic [gam_pkg::SQ_W-1:0]              rem_q, root_q, bit_q;

  logic signed [17:0]                    ad_sq, bc_sq;
  logic [17:0]                           sum_sq;
  logic signed [9:0]                     y_in, x_in;
  logic signed [gam_pkg::XY_W-1:0]       dx, dy;
  logic [gam_pkg::SQ_W-1:0]              trial;
  logic signed [gam_pkg::Z_W-1:0]        z_rnd, z_sh;
  logic [23:0]                           ang_ext;

  assign ad_sq  = ad_i * ad_i;
  assign bc_sq  = bc_i * bc_i;
  assign sum_sq = 18'(ad_sq) + 18'(bc_sq);
  assign y_in   = 10'(ad_i) + 10'(bc_i);
  assign x_in   = 10'(bc_i) - 10'(ad_i);

  assign dx    = y_q >>> step_q;
  assign dy    = x_q >>> step_q;
  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == gam_pkg::STEP_W'(gam_pkg::CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (ad_i == 9'sd0) && (bc_i == 9'sd0);
      rem_q  <= {sum_sq, 7'b0};
      root_q <= '0;
      bit_q  <= gam_pkg::SQ_W'(1) << 24;
      // Fold the left half plane onto the right one.
      if (x_in < 0) begin
        x_q <= gam_pkg::XY_W'(-x_in) <<< 16;
        y_q <= gam_pkg::XY_W'(-y_in) <<< 16;
        z_q <= (y_in >= 0) ? (gam_pkg::Z_W'(1) <<< gam_pkg::ANG_FRAC)
                           : -(gam_pkg::Z_W'(1) <<< gam_pkg::ANG_FRAC);
      end else begin
        x_q <= gam_pkg::XY_W'(x_in) <<< 16;
        y_q <= gam_pkg::XY_W'(y_in) <<< 16;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + gam_pkg::atan_entry(step_q);
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - gam_pkg::atan_entry(step_q);
      end
      if (bit_q != '0) begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign z_rnd   = z_q + (gam_pkg::Z_W'(1) <<< (gam_pkg::ANG_SHIFT - 1));
  assign z_sh    = z_rnd >>> gam_pkg::ANG_SHIFT;
  assign ang_ext = 24'(z_sh[gam_pkg::ANGLE_BITS-1:0]);

  assign done_o      = done_q;
  // The square root remainder tells whether to round the root up.
  assign res_o.norm  = 13'(root_q) + 13'(rem_q > root_q);
  assign res_o.angle = zero_q ? 16'd0 : ang_ext[15:0];

endmodule
`default_nettype wire

FILE: rtl/core/gradient_angle_map.sv
// ----------------------------------------------------------------------------
// gradient_angle_map
// Level-line gradient norm and angle of each 2x2 window of a raster image.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 words
//  in        input      in_valid_i / in_ready_o   pixel_value, frame_start
//  out       output     out_valid_o / out_ready_i map position, norm, angle, flags
//  cfg       input      cfg_valid_i / cfg_ready_o register index and data
//
//  A pixel that completes no window only passes the load state; one that does
//  takes one line store read, then 20 CORDIC steps that also run the square
//  root. The finished word sits in an output register, so the next pixel is
//  accepted while it waits. Reset clears counters and the window pixels; the
//  line store needs no clearing. A stalled output only holds the next window.
//  Register writes are taken only while no pixel is in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module gradient_angle_map (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire [7:0]                        pixel_value_i,
  input  wire                              frame_start_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [9:0]                       map_row_o,
  output logic [9:0]                       map_col_o,
  output logic [12:0]                      gradient_norm_o,
  output logic signed [15:0]               line_angle_o,
  output logic                             map_valid_o,
  output logic                             frame_last_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [gam_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [gam_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  localparam int DW = gam_pkg::DIM_W;

  logic [1:0]                  state_q, state_d;
  logic [10:0]                 img_w_q, img_h_q;
  logic [12:0]                 thresh_q;
  logic [gam_pkg::ROW_W-1:0]   row_cnt_q, r_q;
  logic [gam_pkg::COL_W-1:0]   col_cnt_q, c_q;
  logic [7:0]                  pix_q, prev_q, abv_prev_q;
  logic [9:0]                  mr_q, mc_q;
  logic                        interior_q, last_q;

  logic                        in_fire, start, load_out;
  logic [7:0]                  above;
  logic [DW-1:0]               w, h, mr_x, mc_x;
  logic signed [8:0]           ad, bc;
  logic                        math_done;
  gam_pkg::gam_result_t        math_res;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= 11'd640;
      img_h_q  <= 11'd480;
      thresh_q <= 13'd80;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gam_pkg::CFG_WIDTH:  img_w_q  <= cfg_data_i[10:0];
        gam_pkg::CFG_HEIGHT: img_h_q  <= cfg_data_i[10:0];
        gam_pkg::CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_q < 11'd3) begin
      w = DW'(3);
    end else if (DW'(img_w_q) > DW'(gam_pkg::MAX_WIDTH)) begin
      w = DW'(gam_pkg::MAX_WIDTH);
    end else begin
      w = DW'(img_w_q);
    end
    if (img_h_q < 11'd3) begin
      h = DW'(3);
    end else if (DW'(img_h_q) > DW'(gam_pkg::MAX_HEIGHT)) begin
      h = DW'(gam_pkg::MAX_HEIGHT);
    end else begin
      h = DW'(img_h_q);
    end
  end

  gam_ram #(
    .WIDTH (8),
    .DEPTH (gam_pkg::MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (state_q == S_LOAD),
    .waddr_i (c_q),
    .wdata_i (pix_q),
    .raddr_i (frame_start_i ? '0 : col_cnt_q),
    .rdata_o (above)
  );

  assign ad    = 9'({1'b0, pix_q}) - 9'({1'b0, abv_prev_q});
  assign bc    = 9'({1'b0, above}) - 9'({1'b0, prev_q});
  assign start = (state_q == S_LOAD) && (r_q != '0) && (c_q != '0);
  assign mr_x  = DW'(r_q) - DW'(1);
  assign mc_x  = DW'(c_q) - DW'(1);

  gam_math u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ad_i    (ad),
    .bc_i    (bc),
    .done_o  (math_done),
    .res_o   (math_res)
  );

  assign load_out = (state_q == S_CALC) && math_done && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_LOAD;
      S_LOAD:  state_d = start ? S_CALC : S_IDLE;
      S_CALC:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      prev_q     <= '0;
      abv_prev_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        prev_q     <= pix_q;
        abv_prev_q <= above;
        if (DW'(c_q) + DW'(1) >= w) begin
          col_cnt_q <= '0;
          row_cnt_q <= (DW'(r_q) + DW'(1) >= h) ? '0 : r_q + 1'b1;
        end else begin
          col_cnt_q <= c_q + 1'b1;
          row_cnt_q <= r_q;
        end
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= pixel_value_i;
      r_q   <= frame_start_i ? '0 : row_cnt_q;
      c_q   <= frame_start_i ? '0 : col_cnt_q;
    end
    if (start) begin
      mr_q       <= mr_x[9:0];
      mc_q       <= mc_x[9:0];
      interior_q <= (mr_x >= DW'(1)) && (mr_x + DW'(3) <= h) &&
                    (mc_x >= DW'(1)) && (mc_x + DW'(3) <= w);
      last_q     <= (mr_x == h - DW'(2)) && (mc_x == w - DW'(2));
    end
    if (load_out) begin
      map_row_o       <= mr_q;
      map_col_o       <= mc_q;
      gradient_norm_o <= math_res.norm;
      line_angle_o    <= math_res.angle;
      map_valid_o     <= interior_q && (math_res.norm > thresh_q);
      frame_last_o    <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input accepted while a pixel is in progress");
  a_hold_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(gradient_norm_o)))
    else $error("stalled output word changed");
  a_valid_needs_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && map_valid_o) |-> (gradient_norm_o != 13'd0))
    else $error("valid flag on zero gradient");
`endif

endmodule
`default_nettype wire
